// File: rtl/core/f2c_pkg.sv
`default_nettype none

package f2c_pkg;

  // table size and coordinate format
  localparam int MAX_COARSE = 64;
  localparam int COORD_BITS = 16;

  // derived widths of the exact integer datapath
  localparam int CB    = COORD_BITS;
  localparam int EW    = CB + 1;          // edge vector component
  localparam int SW    = CB + 2;          // three times the centroid
  localparam int DW    = CB + 3;          // three times the centroid minus three times a vertex
  localparam int NW    = 2 * EW + 1;      // normal component
  localparam int WW    = NW + EW + 1;     // edge cross normal component
  localparam int QW    = NW + DW + 2;     // plane offset numerator
  localparam int NUMW  = 2 * QW;          // squared plane offset
  localparam int DENW  = 2 * NW + 2;      // squared normal length
  localparam int DDW   = 2 * DW + 2;      // squared vertex distance
  localparam int ACC_W = NUMW + DENW + 2; // accumulator of the shared unit
  localparam int OPB_W = DENW;            // multiplier operand
  localparam int NB_W  = $clog2(OPB_W + 1);

  localparam int CNT_W     = $clog2(MAX_COARSE + 1);
  localparam int RAM_W     = 3 * CB + 1;
  localparam int RAM_DEPTH = 3 * MAX_COARSE;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int IDXO_W    = 6;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // command to the shared multiply-accumulate unit
  typedef struct packed {
    logic                     start;
    logic                     clr;
    logic                     sub;
    logic [NB_W-1:0]          nb;
    logic signed [ACC_W-1:0]  a;
    logic signed [OPB_W-1:0]  b;
  } mac_cmd_t;

  typedef struct packed {
    logic                     done;
    logic signed [ACC_W-1:0]  acc;
  } mac_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/fine_to_coarse_facet_visibility_link.sv
// Fine-to-coarse facet visibility link.
// Input channel (in_valid/in_ready) carries one request per transaction:
// a load appends a coarse triangle and its hidden flag to the table
// unless it is full, a clear empties the table, a query presents one
// fine triangle. Only a query produces a result transaction on the
// output channel (out_valid/out_ready); unknown request codes are dropped.
// A load accepts the request and then writes the three vertices to the
// table RAM. A query runs every product through one bit-serial
// multiply-accumulate unit: first the fine normal, then for each table
// entry its normal and facing test, for a facing entry the prism test
// and plane distance, and a nearest-vertex fallback over every entry when
// no prism test passes. The block takes one request at a time and in_ready
// is low until the current request is finished and its result taken.
// Reset empties the table and returns to idle; table RAM contents are not
// cleared. A stalled receiver holds the result in place and keeps
// in_ready low.
`default_nettype none

module fine_to_coarse_facet_visibility_link
  import f2c_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] az,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] bz,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] cz,
  input  wire logic                         hidden,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              keep,
  output logic [IDXO_W-1:0]                 coarse_index,
  output logic                              linked,
  output logic                              by_vertex
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_QNF   = 4'd2;
  localparam logic [3:0] S_ERD   = 4'd3;
  localparam logic [3:0] S_EN    = 4'd4;
  localparam logic [3:0] S_EFACE = 4'd5;
  localparam logic [3:0] S_EW    = 4'd6;
  localparam logic [3:0] S_EWD   = 4'd7;
  localparam logic [3:0] S_EQ    = 4'd8;
  localparam logic [3:0] S_ENUM  = 4'd9;
  localparam logic [3:0] S_EDEN  = 4'd10;
  localparam logic [3:0] S_ECMP  = 4'd11;
  localparam logic [3:0] S_FRD   = 4'd12;
  localparam logic [3:0] S_FDD   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state;
  logic [2:0] step;
  logic [1:0] k;
  logic [1:0] rc;
  logic [1:0] fv;
  logic [1:0] ldv;
  logic       pend;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] best;
  logic             found;
  logic             byv;
  logic             bhid;

  // request payload, held for the whole transaction
  logic signed [CB-1:0] fin [9];
  logic                 hid_in;

  // coarse entry under test and fallback vertex
  logic signed [CB-1:0] cv [9];
  logic                 chid;
  logic signed [CB-1:0] tv [3];
  logic                 thid;

  // products kept between steps
  logic signed [NW-1:0]   nf [3];
  logic signed [NW-1:0]   n  [3];
  logic signed [WW-1:0]   w  [3];
  logic signed [QW-1:0]   q;
  logic signed [NUMW-1:0] num;
  logic signed [DENW-1:0] den;
  logic signed [NUMW-1:0] bnum;
  logic signed [DENW-1:0] bden;
  logic [DDW-1:0]         bestd;

  // derived vectors
  logic signed [EW-1:0] fe1 [3];
  logic signed [EW-1:0] fe2 [3];
  logic signed [SW-1:0] s   [3];
  logic signed [EW-1:0] ce1 [3];
  logic signed [EW-1:0] ce2 [3];
  logic signed [EW-1:0] ek  [3];
  logic signed [DW-1:0] dk  [3];
  logic signed [DW-1:0] d1  [3];
  logic signed [DW-1:0] t   [3];
  logic signed [CB-1:0] eu  [3];
  logic signed [CB-1:0] evv [3];

  logic [1:0] ua;
  logic [1:0] vb;
  logic [1:0] di;
  logic       odd;
  logic       last;
  logic       computing;
  logic       issue;
  logic       acc_pos;
  logic       acc_neg;
  logic       fin_done;
  logic       go_next;
  logic       take;
  logic       more;
  logic [DDW-1:0] dd;

  mac_cmd_t cmd;
  mac_rsp_t rsp;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;

  f2c_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  f2c_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // edge vectors, centroid sums and offsets
  always_comb begin
    unique case (k)
      2'd0: begin
        eu  = '{cv[0], cv[1], cv[2]};
        evv = '{cv[3], cv[4], cv[5]};
      end
      2'd1: begin
        eu  = '{cv[3], cv[4], cv[5]};
        evv = '{cv[6], cv[7], cv[8]};
      end
      default: begin
        eu  = '{cv[6], cv[7], cv[8]};
        evv = '{cv[0], cv[1], cv[2]};
      end
    endcase
    for (int j = 0; j < 3; j++) begin
      fe1[j] = EW'(fin[3+j]) - EW'(fin[j]);
      fe2[j] = EW'(fin[6+j]) - EW'(fin[3+j]);
      s[j]   = SW'(fin[j]) + SW'(fin[3+j]) + SW'(fin[6+j]);
      ce1[j] = EW'(cv[3+j]) - EW'(cv[j]);
      ce2[j] = EW'(cv[6+j]) - EW'(cv[3+j]);
      ek[j]  = EW'(evv[j]) - EW'(eu[j]);
      dk[j]  = DW'(s[j]) - ((DW'(eu[j]) <<< 1) + DW'(eu[j]));
      d1[j]  = DW'(s[j]) - ((DW'(cv[j]) <<< 1) + DW'(cv[j]));
      t[j]   = ((DW'(tv[j]) <<< 1) + DW'(tv[j])) - DW'(s[j]);
    end
  end

  // cross product term order: component j uses (j+1, j+2) then (j+2, j+1)
  always_comb begin
    odd = step[0];
    di  = step[1:0];
    unique case (step[2:1])
      2'd0:    begin ua = odd ? 2'd2 : 2'd1; vb = odd ? 2'd1 : 2'd2; end
      2'd1:    begin ua = odd ? 2'd0 : 2'd2; vb = odd ? 2'd2 : 2'd0; end
      default: begin ua = odd ? 2'd1 : 2'd0; vb = odd ? 2'd0 : 2'd1; end
    endcase
  end

  assign computing = (state == S_QNF) || (state == S_EN) || (state == S_EFACE) ||
                     (state == S_EW) || (state == S_EWD) || (state == S_EQ) ||
                     (state == S_ENUM) || (state == S_EDEN) || (state == S_ECMP) ||
                     (state == S_FDD);
  assign issue    = computing && !pend;
  assign acc_pos  = !rsp.acc[ACC_W-1] && (rsp.acc != '0);
  assign acc_neg  = rsp.acc[ACC_W-1];
  assign dd       = rsp.acc[DDW-1:0];
  assign more     = CNT_W'(idx + CNT_W'(1)) < count;

  // last term of each operation
  always_comb begin
    unique case (state)
      S_QNF, S_EN, S_EW:                    last = (step == 3'd5);
      S_EFACE, S_EWD, S_EQ, S_EDEN, S_FDD:  last = (step == 3'd2);
      S_ECMP:                               last = (step == 3'd1);
      default:                              last = 1'b1;
    endcase
  end

  assign fin_done = rsp.done && last;
  assign take     = fin_done && (((state == S_EDEN) && !found) ||
                                 ((state == S_ECMP) && acc_neg));
  assign go_next  = fin_done && (((state == S_EFACE) && !acc_pos) ||
                                 ((state == S_EWD) && acc_pos) ||
                                 ((state == S_EDEN) && !found) ||
                                 (state == S_ECMP));

  // operand selection for the shared unit
  always_comb begin
    cmd       = '0;
    cmd.start = issue;
    unique case (state)
      S_QNF: begin
        cmd.a = ACC_W'(fe1[ua]); cmd.b = OPB_W'(fe2[vb]); cmd.nb = NB_W'(EW);
        cmd.clr = !odd; cmd.sub = odd;
      end
      S_EN: begin
        cmd.a = ACC_W'(ce1[ua]); cmd.b = OPB_W'(ce2[vb]); cmd.nb = NB_W'(EW);
        cmd.clr = !odd; cmd.sub = odd;
      end
      S_EW: begin
        cmd.a = ACC_W'(n[vb]); cmd.b = OPB_W'(ek[ua]); cmd.nb = NB_W'(EW);
        cmd.clr = !odd; cmd.sub = odd;
      end
      S_EFACE: begin
        cmd.a = ACC_W'(nf[di]); cmd.b = OPB_W'(n[di]); cmd.nb = NB_W'(NW);
        cmd.clr = (step == 3'd0);
      end
      S_EWD: begin
        cmd.a = ACC_W'(w[di]); cmd.b = OPB_W'(dk[di]); cmd.nb = NB_W'(DW);
        cmd.clr = (step == 3'd0);
      end
      S_EQ: begin
        cmd.a = ACC_W'(n[di]); cmd.b = OPB_W'(d1[di]); cmd.nb = NB_W'(DW);
        cmd.clr = (step == 3'd0);
      end
      S_ENUM: begin
        cmd.a = ACC_W'(q); cmd.b = OPB_W'(q); cmd.nb = NB_W'(QW);
        cmd.clr = 1'b1;
      end
      S_EDEN: begin
        cmd.a = ACC_W'(n[di]); cmd.b = OPB_W'(n[di]); cmd.nb = NB_W'(NW);
        cmd.clr = (step == 3'd0);
      end
      S_ECMP: begin
        cmd.nb = NB_W'(DENW);
        if (step == 3'd0) begin
          cmd.a = ACC_W'(num); cmd.b = OPB_W'(bden); cmd.clr = 1'b1;
        end else begin
          cmd.a = ACC_W'(bnum); cmd.b = OPB_W'(den); cmd.sub = 1'b1;
        end
      end
      S_FDD: begin
        cmd.a = ACC_W'(t[di]); cmd.b = OPB_W'(t[di]); cmd.nb = NB_W'(DW);
        cmd.clr = (step == 3'd0);
      end
      default: ;
    endcase
  end

  // table RAM ports
  always_comb begin
    ram_we    = (state == S_LOAD);
    ram_waddr = RAM_AW'({count, 1'b0}) + RAM_AW'(count) + RAM_AW'(ldv);
    unique case (ldv)
      2'd0:    ram_wdata = {hid_in, fin[2], fin[1], fin[0]};
      2'd1:    ram_wdata = {hid_in, fin[5], fin[4], fin[3]};
      default: ram_wdata = {hid_in, fin[8], fin[7], fin[6]};
    endcase
    if (state == S_FRD) begin
      ram_raddr = RAM_AW'({idx, 1'b0}) + RAM_AW'(idx) + RAM_AW'(fv);
    end else begin
      ram_raddr = RAM_AW'({idx, 1'b0}) + RAM_AW'(idx) +
                  ((rc == 2'd3) ? RAM_AW'(0) : RAM_AW'(rc));
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fin    <= '{ax, ay, az, bx, by, bz, cx, cy, cz};
      hid_in <= hidden;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      step  <= '0;
      k     <= '0;
      rc    <= '0;
      fv    <= '0;
      ldv   <= '0;
      idx   <= '0;
      best  <= '0;
      found <= 1'b0;
      byv   <= 1'b0;
      bhid  <= 1'b0;
    end else begin
      if (issue) begin
        pend <= 1'b1;
      end
      if (rsp.done) begin
        pend <= 1'b0;
        if (!last) begin
          step <= step + 3'd1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (req_type)
              REQ_LOAD: begin
                if (count < CNT_W'(MAX_COARSE)) begin
                  state <= S_LOAD;
                  ldv   <= '0;
                end
              end
              REQ_QUERY: begin
                state <= S_QNF;
                step  <= '0;
                found <= 1'b0;
                byv   <= 1'b0;
                best  <= '0;
                bhid  <= 1'b0;
              end
              REQ_CLEAR: count <= '0;
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          ldv <= ldv + 2'd1;
          if (ldv == 2'd2) begin
            count <= count + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        S_QNF: begin
          if (rsp.done && odd) begin
            nf[step[2:1]] <= rsp.acc[NW-1:0];
          end
          if (fin_done) begin
            if (count == '0) begin
              state <= S_OUT;
            end else begin
              idx   <= '0;
              rc    <= '0;
              state <= S_ERD;
            end
          end
        end
        S_ERD: begin
          unique case (rc)
            2'd1: begin
              cv[0] <= ram_rdata[CB-1:0];
              cv[1] <= ram_rdata[2*CB-1:CB];
              cv[2] <= ram_rdata[3*CB-1:2*CB];
              chid  <= ram_rdata[RAM_W-1];
            end
            2'd2: begin
              cv[3] <= ram_rdata[CB-1:0];
              cv[4] <= ram_rdata[2*CB-1:CB];
              cv[5] <= ram_rdata[3*CB-1:2*CB];
            end
            2'd3: begin
              cv[6] <= ram_rdata[CB-1:0];
              cv[7] <= ram_rdata[2*CB-1:CB];
              cv[8] <= ram_rdata[3*CB-1:2*CB];
            end
            default: ;
          endcase
          if (rc == 2'd3) begin
            state <= S_EN;
            step  <= '0;
          end else begin
            rc <= rc + 2'd1;
          end
        end
        S_EN: begin
          if (rsp.done && odd) begin
            n[step[2:1]] <= rsp.acc[NW-1:0];
          end
          if (fin_done) begin
            state <= S_EFACE;
            step  <= '0;
          end
        end
        S_EFACE: begin
          if (fin_done && acc_pos) begin
            state <= S_EW;
            k     <= '0;
            step  <= '0;
          end
        end
        S_EW: begin
          if (rsp.done && odd) begin
            w[step[2:1]] <= rsp.acc[WW-1:0];
          end
          if (fin_done) begin
            state <= S_EWD;
            step  <= '0;
          end
        end
        S_EWD: begin
          if (fin_done && !acc_pos) begin
            step <= '0;
            if (k == 2'd2) begin
              state <= S_EQ;
            end else begin
              k     <= k + 2'd1;
              state <= S_EW;
            end
          end
        end
        S_EQ: begin
          if (fin_done) begin
            q     <= rsp.acc[QW-1:0];
            state <= S_ENUM;
            step  <= '0;
          end
        end
        S_ENUM: begin
          if (fin_done) begin
            num   <= rsp.acc[NUMW-1:0];
            state <= S_EDEN;
            step  <= '0;
          end
        end
        S_EDEN: begin
          if (fin_done) begin
            den <= rsp.acc[DENW-1:0];
            if (found) begin
              state <= S_ECMP;
              step  <= '0;
            end
          end
        end
        S_ECMP: ;
        S_FRD: begin
          if (rc == 2'd0) begin
            rc <= 2'd1;
          end else begin
            tv[0] <= ram_rdata[CB-1:0];
            tv[1] <= ram_rdata[2*CB-1:CB];
            tv[2] <= ram_rdata[3*CB-1:2*CB];
            thid  <= ram_rdata[RAM_W-1];
            state <= S_FDD;
            step  <= '0;
          end
        end
        S_FDD: begin
          if (fin_done) begin
            if (!found || (dd < bestd)) begin
              found <= 1'b1;
              byv   <= 1'b1;
              best  <= idx;
              bestd <= dd;
              bhid  <= thid;
            end
            rc <= '0;
            if (fv != 2'd2) begin
              fv    <= fv + 2'd1;
              state <= S_FRD;
            end else if (more) begin
              fv    <= '0;
              idx   <= idx + CNT_W'(1);
              state <= S_FRD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // candidate accepted by the prism and distance tests
      if (take) begin
        found <= 1'b1;
        best  <= idx;
        bhid  <= chid;
        bnum  <= num;
        bden  <= (state == S_EDEN) ? rsp.acc[DENW-1:0] : den;
      end

      // advance to the next entry or fall back to nearest vertex
      if (go_next) begin
        rc <= '0;
        if (more) begin
          idx   <= idx + CNT_W'(1);
          state <= S_ERD;
        end else if (found || take) begin
          state <= S_OUT;
        end else begin
          idx   <= '0;
          fv    <= '0;
          state <= S_FRD;
        end
      end
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign keep         = found && !bhid;
  assign coarse_index = IDXO_W'(best);
  assign linked       = found;
  assign by_vertex    = byv;

  // result and input channels are never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output channels active together");

  // table fill stays within capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_COARSE))
    else $error("coarse table count beyond capacity");

  // an unlinked result carries no target
  a_unlinked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !linked) |-> (!keep && !by_vertex && (coarse_index == '0)))
    else $error("unlinked result with target fields set");

  // clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (req_type == REQ_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the table");

endmodule

`default_nettype wire

// File: rtl/core/f2c_ram.sv
`default_nettype none

module f2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/f2c_mac.sv
`default_nettype none

module f2c_mac
  import f2c_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mac_cmd_t cmd,
  output mac_rsp_t      rsp
);

  logic                    busy;
  logic                    done;
  logic [NB_W-1:0]         cnt;
  logic                    subr;
  logic signed [ACC_W-1:0] areg;
  logic [OPB_W-1:0]        breg;
  logic signed [ACC_W-1:0] acc;
  logic                    neg;

  // top multiplier bit carries negative weight
  assign neg = subr ^ (cnt == NB_W'(1));

  // sequencing of the bit-serial product
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nb;
      end else if (busy) begin
        cnt <= cnt - NB_W'(1);
        if (cnt == NB_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      areg <= cmd.a;
      breg <= cmd.b;
      subr <= cmd.sub;
      if (cmd.clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (breg[0]) begin
        acc <= neg ? (acc - areg) : (acc + areg);
      end
      areg <= areg <<< 1;
      breg <= breg >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.acc  = acc;

endmodule

`default_nettype wire

// File: dv/f2c_link_checker.sv
`timescale 1ns / 1ps

module f2c_link_checker
  import f2c_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] az,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] bz,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] cz,
  input  wire logic                         hidden,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic                         keep,
  input  wire logic [IDXO_W-1:0]            coarse_index,
  input  wire logic                         linked,
  input  wire logic                         by_vertex,
  output int                                errors,
  output int                                pending
);

  localparam int EXP_DEPTH = 16;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t tri_t [9];
  typedef struct packed { wide_t x; wide_t y; wide_t z; } vec3_t;
  typedef struct packed {
    logic              keep;
    logic [IDXO_W-1:0] idx;
    logic              linked;
    logic              by_vertex;
  } link_t;

  // shadow of the coarse table
  tri_t   coarse_tri [MAX_COARSE];
  logic   coarse_hid [MAX_COARSE];
  int     coarse_cnt;

  // predictions waiting for their result transaction
  link_t  exp_buf [EXP_DEPTH];
  int     wr_ptr;
  int     rd_ptr;

  function automatic vec3_t cross3(vec3_t u, vec3_t v);
    vec3_t r;
    r.x = u.y * v.z - u.z * v.y;
    r.y = u.z * v.x - u.x * v.z;
    r.z = u.x * v.y - u.y * v.x;
    return r;
  endfunction

  function automatic wide_t dot3(vec3_t u, vec3_t v);
    return u.x * v.x + u.y * v.y + u.z * v.z;
  endfunction

  // normal is (b-a) x (c-b)
  function automatic vec3_t tri_normal(tri_t p);
    vec3_t e1, e2;
    e1.x = p[3] - p[0]; e1.y = p[4] - p[1]; e1.z = p[5] - p[2];
    e2.x = p[6] - p[3]; e2.y = p[7] - p[4]; e2.z = p[8] - p[5];
    return cross3(e1, e2);
  endfunction

  function automatic link_t predict_link(tri_t f);
    link_t res;
    vec3_t nf, n, e, d, d1, w, s;
    wide_t q, num, den, best_num, best_den, dd, best_dd, t;
    logic  found, from_vertex, in_prism;
    int    best, a, b;
    nf = tri_normal(f);
    s.x = f[0] + f[3] + f[6];
    s.y = f[1] + f[4] + f[7];
    s.z = f[2] + f[5] + f[8];
    found = 0;
    from_vertex = 0;
    best = 0;
    best_num = 0;
    best_den = 1;
    best_dd = 0;
    d1 = '0;
    // facing entries whose prism holds the centroid, least plane distance
    for (int i = 0; i < coarse_cnt; i++) begin
      n = tri_normal(coarse_tri[i]);
      if (dot3(nf, n) <= 0) continue;
      in_prism = 1;
      for (int k = 0; k < 3; k++) begin
        a = 3 * k;
        b = 3 * ((k + 1) % 3);
        e.x = coarse_tri[i][b] - coarse_tri[i][a];
        e.y = coarse_tri[i][b+1] - coarse_tri[i][a+1];
        e.z = coarse_tri[i][b+2] - coarse_tri[i][a+2];
        d.x = s.x - 3 * wide_t'(coarse_tri[i][a]);
        d.y = s.y - 3 * wide_t'(coarse_tri[i][a+1]);
        d.z = s.z - 3 * wide_t'(coarse_tri[i][a+2]);
        if (k == 0) d1 = d;
        w = cross3(e, n);
        if (dot3(w, d) > 0) in_prism = 0;
      end
      if (in_prism) begin
        q = dot3(n, d1);
        num = q * q;
        den = dot3(n, n);
        if (!found || num * best_den < best_num * den) begin
          found = 1;
          best = i;
          best_num = num;
          best_den = den;
        end
      end
    end
    // nearest vertex fallback over every entry
    if (!found) begin
      for (int i = 0; i < coarse_cnt; i++) begin
        for (int k = 0; k < 3; k++) begin
          t = 3 * wide_t'(coarse_tri[i][3*k]) - s.x;
          dd = t * t;
          t = 3 * wide_t'(coarse_tri[i][3*k+1]) - s.y;
          dd = dd + t * t;
          t = 3 * wide_t'(coarse_tri[i][3*k+2]) - s.z;
          dd = dd + t * t;
          if (!found || dd < best_dd) begin
            found = 1;
            from_vertex = 1;
            best = i;
            best_dd = dd;
          end
        end
      end
    end
    if (found) begin
      res.keep = !coarse_hid[best];
      res.idx = best[IDXO_W-1:0];
      res.linked = 1;
      res.by_vertex = from_vertex;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  assign pending = wr_ptr - rd_ptr;

  // input transactions update the shadow table or queue a prediction
  always @(posedge clk) begin
    tri_t  f;
    if (rst) begin
      coarse_cnt <= 0;
      wr_ptr     <= 0;
    end else if (in_valid && in_ready) begin
      f = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      case (req_type)
        REQ_LOAD: begin
          if (coarse_cnt < MAX_COARSE) begin
            coarse_tri[coarse_cnt] = f;
            coarse_hid[coarse_cnt] = hidden;
            coarse_cnt <= coarse_cnt + 1;
          end
        end
        REQ_CLEAR: coarse_cnt <= 0;
        REQ_QUERY: begin
          exp_buf[wr_ptr % EXP_DEPTH] <= predict_link(f);
          wr_ptr <= wr_ptr + 1;
        end
        default: ;
      endcase
    end
  end

  // result transactions against the oldest prediction
  always @(posedge clk) begin
    link_t exp_l;
    if (rst) begin
      rd_ptr <= 0;
    end else if (out_valid && out_ready) begin
      if (rd_ptr == wr_ptr) begin
        report("unexpected result, index", -1, coarse_index);
      end else begin
        exp_l = exp_buf[rd_ptr % EXP_DEPTH];
        rd_ptr <= rd_ptr + 1;
        if (keep !== exp_l.keep) report("keep", exp_l.keep, keep);
        if (coarse_index !== exp_l.idx) report("coarse_index", exp_l.idx, coarse_index);
        if (linked !== exp_l.linked) report("linked", exp_l.linked, linked);
        if (by_vertex !== exp_l.by_vertex) report("by_vertex", exp_l.by_vertex, by_vertex);
      end
    end
  end

  initial errors = 0;

endmodule

// File: dv/tb_fine_to_coarse_facet_visibility_link.sv
`timescale 1ns / 1ps

module tb_fine_to_coarse_facet_visibility_link;
  import f2c_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1800;
  localparam logic [1:0] REQ_BOGUS = 2'd3;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] req_type;
  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic hidden, keep, linked, by_vertex;
  logic [IDXO_W-1:0] coarse_index;
  int errors, pending;
  int items_sent, results_seen, idle_cycles, big_tables;
  int loaded [MAX_COARSE][9];
  int n_loaded;

  fine_to_coarse_facet_visibility_link u_top (.*);

  f2c_link_checker u_chk (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid && out_ready) results_seen <= results_seen + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_fine_to_coarse_facet_visibility_link failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one input transaction, waits for acceptance, then an optional gap
  task automatic send(input logic [1:0] rt, input int v [9], input logic hid);
    int g;
    in_valid <= 1'b1;
    req_type <= rt;
    ax <= v[0]; ay <= v[1]; az <= v[2];
    bx <= v[3]; by <= v[4]; bz <= v[5];
    cx <= v[6]; cy <= v[7]; cz <= v[8];
    hidden <= hid;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (rt != REQ_BOGUS) items_sent++;
    if (rt == REQ_LOAD && n_loaded < MAX_COARSE) begin
      loaded[n_loaded] = v;
      n_loaded++;
    end
    if (rt == REQ_CLEAR) n_loaded = 0;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic void rand_tri(output int v [9], input int span);
    for (int k = 0; k < 9; k++) v[k] = $urandom_range(0, 2 * span) - span;
  endfunction

  // fine triangle shrunk toward a coarse centroid, optionally flipped
  function automatic void fine_in(output int v [9], input int idx, input logic flip);
    int cen [3];
    for (int j = 0; j < 3; j++)
      cen[j] = (loaded[idx][j] + loaded[idx][3+j] + loaded[idx][6+j]) / 3;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        v[3*k+j] = (loaded[idx][3*k+j] + cen[j]) / 2 + $urandom_range(0, 80) - 40;
    if (flip)
      for (int j = 0; j < 3; j++) begin
        int t;
        t = v[3+j]; v[3+j] = v[6+j]; v[6+j] = t;
      end
  endfunction

  task automatic load_random(input int span);
    int v [9];
    rand_tri(v, span);
    send(REQ_LOAD, v, $urandom_range(0, 1));
  endtask

  task automatic random_query();
    int v [9];
    int r;
    r = $urandom_range(0, 99);
    if (n_loaded > 0 && r < 70) fine_in(v, $urandom_range(0, n_loaded - 1), 0);
    else if (n_loaded > 0 && r < 80) fine_in(v, $urandom_range(0, n_loaded - 1), 1);
    else if (r < 90) rand_tri(v, 32767);
    else begin
      rand_tri(v, 20000);
      for (int j = 0; j < 3; j++) v[6+j] = v[3+j];
    end
    send(REQ_QUERY, v, $urandom_range(0, 1));
  endtask

  // receiver: random ready runs plus one long hold-off
  initial begin
    int len;
    logic held;
    out_ready = 1'b0;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && results_seen >= 20) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
      out_ready <= ($urandom_range(0, 3) != 0);
      repeat (len) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int v [9];
    int nq, nl;
    in_valid = 1'b0;
    req_type = REQ_LOAD;
    {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
    hidden = 1'b0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    big_tables = 0;
    n_loaded = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, ties, hidden, unknown code
    v = '{0, 0, 0, 100, 0, 0, 0, 100, 0};
    send(REQ_QUERY, v, 0);
    send(REQ_LOAD, '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0}, 1);
    send(REQ_LOAD, '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0}, 0);
    send(REQ_LOAD, '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0);
    send(REQ_LOAD, '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                     -32768}, 1);
    send(REQ_QUERY, '{-100, -100, 0, 100, -100, 0, -100, 100, 0}, 0);
    send(REQ_QUERY, '{-100, -100, 0, -100, 100, 0, 100, -100, 0}, 0);
    send(REQ_QUERY, '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1);
    send(REQ_QUERY, '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768}, 0);
    send(REQ_BOGUS, '{5, 5, 5, 5, 5, 5, 5, 5, 5}, 1);
    send(REQ_LOAD, '{0, 0, 500, 1000, 0, 500, 0, 1000, 500}, 0);
    send(REQ_QUERY, '{100, 100, 300, 300, 100, 300, 100, 300, 300}, 0);
    send(REQ_CLEAR, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0);
    send(REQ_QUERY, '{-1, -1, -1, 1, 1, 1, 1, -1, 1}, 1);

    // random: mostly small tables with well-formed queries
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0) send(REQ_CLEAR, v, $urandom_range(0, 1));
      if (big_tables < 2 && items_sent > 400 * (big_tables + 1)) begin
        big_tables++;
        nl = $urandom_range(MAX_COARSE, MAX_COARSE + 3);
        nq = 2;
      end else begin
        nl = $urandom_range(1, 6);
        nq = $urandom_range(2, 8);
      end
      for (int i = 0; i < nl; i++) load_random($urandom_range(0, 3) == 0 ? 32767 : 12000);
      // duplicate entry now and then for distance ties
      if ($urandom_range(0, 5) == 0 && n_loaded > 0 && n_loaded < MAX_COARSE)
        send(REQ_LOAD, loaded[$urandom_range(0, n_loaded - 1)], $urandom_range(0, 1));
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 19) == 0) send(REQ_BOGUS, v, 0);
        random_query();
      end
    end

    in_valid <= 1'b0;
    // let the prediction for the last accepted transaction settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_fine_to_coarse_facet_visibility_link passed");
    end else begin
      $display("tb_fine_to_coarse_facet_visibility_link failed");
    end
    $finish;
  end

endmodule

// File: fine_to_coarse_facet_visibility_link.f
rtl/core/f2c_pkg.sv
rtl/core/f2c_ram.sv
rtl/core/f2c_mac.sv
rtl/core/fine_to_coarse_facet_visibility_link.sv
dv/f2c_link_checker.sv
dv/tb_fine_to_coarse_facet_visibility_link.sv
